[src/local_mean_adaptive_threshold_assert.svh]
// Assertion macros shared by the threshold block.
`ifndef LOCAL_MEAN_ADAPTIVE_THRESHOLD_ASSERT_SVH
`define LOCAL_MEAN_ADAPTIVE_THRESHOLD_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LMAT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmat assertion failed");

// Next-cycle implication, checked outside reset.
`define LMAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmat assertion failed");

`endif

[src/lmat_pkg.sv]
// Package of the threshold block: sizes, payload types and state codes.
`default_nettype none
package lmat_pkg;
    localparam int MAX_WIDTH       = 2048;
    localparam int MAX_HEIGHT      = 4096;
    localparam int MAX_HALF_WINDOW = 31;
    localparam int MAX_RESULTS     = 32;

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int HW_W   = $clog2(MAX_HALF_WINDOW + 1);
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int SLOT_BITS = $clog2(2 * (MAX_HALF_WINDOW + 1));
    localparam int MEM_AW    = SLOT_BITS + COL_BITS;
    localparam int MEM_DEPTH = 2 ** MEM_AW;
    localparam int DIM_W  = $clog2(2 * MAX_HALF_WINDOW + 2);
    localparam int CNT_W  = $clog2((2 * MAX_HALF_WINDOW + 1) ** 2 + 1);
    localparam int SUM_W  = $clog2((2 * MAX_HALF_WINDOW + 1) ** 2 * 255 + 1);
    localparam int N_W    = $clog2(MAX_RESULTS + 1);
    localparam int HWID_MAX = (MAX_HALF_WINDOW < MAX_RESULTS - 1) ?
                              MAX_HALF_WINDOW : MAX_RESULTS - 1;

    localparam logic [7:0] BRIGHT = 8'd255;
    localparam logic [7:0] DARK   = 8'd0;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_HALF_HEIGHT  = 3'd2,
        CFG_HALF_WIDTH   = 3'd3,
        CFG_RATIO        = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SUM,
        ST_SUMW,
        ST_MUL,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pixel_value;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_value;
        logic [11:0] out_row;
        logic [10:0] out_col;
        logic        frame_last;
        logic        run_last;
    } out_t;
endpackage
`default_nettype wire

[src/lmat_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lmat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/local_mean_adaptive_threshold.sv]
// Top level of the local-mean adaptive threshold block.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | lmat_pkg::in_t
//  out     | output    | out_valid / out_ready| lmat_pkg::out_t
//  cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// An input item is accepted and then produces its results; an item that releases
// nothing is accepted and then goes through the window check, and a pixel past a
// complete frame is only accepted. Each result takes the window check, then one
// row-store read per window pixel through the single read port, then the product
// and compare steps, and then waits in ST_OUT while out_ready stays low.
// One item is in work at a time; a result waits in the output register.
// No clearing pass after reset; the row store is only read where written.
`default_nettype none
module local_mean_adaptive_threshold (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire lmat_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output lmat_pkg::out_t       out_data,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [15:0]     cfg_wdata
);
    localparam int ROW_W = lmat_pkg::ROW_W;
    localparam int COL_W = lmat_pkg::COL_W;
    localparam int HW_W  = lmat_pkg::HW_W;

    lmat_pkg::state_t state_reg, state_next;

    logic [11:0] fw_reg, fw_next;
    logic [12:0] fh_reg, fh_next;
    logic [4:0]  hh_cfg_reg, hh_cfg_next;
    logic [4:0]  hw_cfg_reg, hw_cfg_next;
    logic [15:0] ratio_reg, ratio_next;

    logic [ROW_W-1:0] in_row_reg, in_row_next, emit_row_reg, emit_row_next;
    logic [COL_W-1:0] in_col_reg, in_col_next, emit_col_reg, emit_col_next;
    logic [ROW_W-1:0] pr_reg, pr_next;
    logic             drain_reg, drain_next;
    logic             end_reg, end_next;
    logic [lmat_pkg::N_W-1:0] n_reg, n_next;

    logic [ROW_W-1:0] tlr_reg, tlr_next, brr_reg, brr_next, r_reg, r_next;
    logic [COL_W-1:0] tlc_reg, tlc_next, brc_reg, brc_next, c_reg, c_next;
    logic             first_reg, first_next, accv_reg, accv_next;

    logic [7:0]                   pix_reg, pix_next;
    logic [lmat_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [lmat_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [lmat_pkg::CNT_W+7:0]   lhsp_reg, lhsp_next;
    logic [lmat_pkg::SUM_W+16:0]  rhs_reg, rhs_next;
    lmat_pkg::out_t               out_reg, out_next;

    // effective configuration
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [HW_W-1:0]  hh_eff, hw_eff;

    always_comb
    begin
        if (fw_reg == '0)
            w_eff = COL_W'(1);
        else if (int'(fw_reg) > lmat_pkg::MAX_WIDTH)
            w_eff = COL_W'(lmat_pkg::MAX_WIDTH);
        else
            w_eff = COL_W'(fw_reg);
        if (fh_reg == '0)
            h_eff = ROW_W'(1);
        else if (int'(fh_reg) > lmat_pkg::MAX_HEIGHT)
            h_eff = ROW_W'(lmat_pkg::MAX_HEIGHT);
        else
            h_eff = ROW_W'(fh_reg);
        hh_eff = (int'(hh_cfg_reg) > lmat_pkg::MAX_HALF_WINDOW) ?
                 HW_W'(lmat_pkg::MAX_HALF_WINDOW) : HW_W'(hh_cfg_reg);
        hw_eff = (int'(hw_cfg_reg) > lmat_pkg::HWID_MAX) ?
                 HW_W'(lmat_pkg::HWID_MAX) : HW_W'(hw_cfg_reg);
    end

    // window of the next result
    logic [ROW_W:0]   er_hh;
    logic [COL_W:0]   ec_hw;
    logic [ROW_W-1:0] br_r, tl_r;
    logic [COL_W-1:0] br_c, tl_c;
    logic             win_ready, cond, more, is_last;

    always_comb
    begin
        er_hh = {1'b0, emit_row_reg} + (ROW_W+1)'(hh_eff);
        ec_hw = {1'b0, emit_col_reg} + (COL_W+1)'(hw_eff);
        br_r  = (er_hh < (ROW_W+1)'(h_eff)) ? ROW_W'(er_hh) : h_eff - ROW_W'(1);
        br_c  = (ec_hw < (COL_W+1)'(w_eff)) ? COL_W'(ec_hw) : w_eff - COL_W'(1);
        tl_r  = (emit_row_reg > ROW_W'(hh_eff)) ? emit_row_reg - ROW_W'(hh_eff) : '0;
        tl_c  = (emit_col_reg > COL_W'(hw_eff)) ? emit_col_reg - COL_W'(hw_eff) : '0;
        // raster compare of the window corner against the next input position
        win_ready = (br_r < in_row_reg) || ((br_r == in_row_reg) && (br_c < in_col_reg));
        cond = (emit_row_reg < h_eff) && win_ready &&
               (drain_reg || (er_hh <= (ROW_W+1)'(pr_reg)));
        more = !drain_reg && !end_reg && (int'(n_reg) < lmat_pkg::MAX_RESULTS) && cond;
        is_last = (emit_row_reg == h_eff - ROW_W'(1)) && (emit_col_reg == w_eff - COL_W'(1));
    end

    // row store
    logic                          mem_we;
    logic [lmat_pkg::MEM_AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]                    mem_rdata;

    assign mem_we    = in_valid && in_ready && !in_data.req_type && (in_row_reg < h_eff);
    assign mem_waddr = {lmat_pkg::SLOT_BITS'(in_row_reg), lmat_pkg::COL_BITS'(in_col_reg)};

    always_comb
    begin
        if (state_reg == lmat_pkg::ST_EVAL)
            mem_raddr = {lmat_pkg::SLOT_BITS'(emit_row_reg),
                         lmat_pkg::COL_BITS'(emit_col_reg)};
        else
            mem_raddr = {lmat_pkg::SLOT_BITS'(r_reg), lmat_pkg::COL_BITS'(c_reg)};
    end

    lmat_ram #(
        .WIDTH (8),
        .DEPTH (lmat_pkg::MEM_DEPTH)
    ) u_row_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_data.pixel_value),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == lmat_pkg::ST_IDLE);
    assign out_valid = (state_reg == lmat_pkg::ST_OUT);

    always_comb
    begin
        out_data          = out_reg;
        out_data.run_last = !more;
    end

    always_comb
    begin
        state_next    = state_reg;
        fw_next       = fw_reg;
        fh_next       = fh_reg;
        hh_cfg_next   = hh_cfg_reg;
        hw_cfg_next   = hw_cfg_reg;
        ratio_next    = ratio_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;
        pr_next       = pr_reg;
        drain_next    = drain_reg;
        end_next      = end_reg;
        n_next        = n_reg;
        tlr_next      = tlr_reg;
        tlc_next      = tlc_reg;
        brr_next      = brr_reg;
        brc_next      = brc_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        first_next    = first_reg;
        accv_next     = accv_reg;
        pix_next      = pix_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        lhsp_next     = lhsp_reg;
        rhs_next      = rhs_reg;
        out_next      = out_reg;

        unique case (state_reg)
            lmat_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    drain_next = in_data.req_type;
                    end_next   = 1'b0;
                    n_next     = '0;
                    if (in_data.req_type)
                    begin
                        state_next = lmat_pkg::ST_EVAL;
                    end
                    else if (in_row_reg < h_eff)
                    begin
                        pr_next = in_row_reg;
                        if (in_col_reg + COL_W'(1) >= w_eff)
                        begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            in_col_next = in_col_reg + COL_W'(1);
                        end
                        state_next = lmat_pkg::ST_EVAL;
                    end
                end
            end
            lmat_pkg::ST_EVAL:
            begin
                if (cond)
                begin
                    tlr_next   = tl_r;
                    tlc_next   = tl_c;
                    brr_next   = br_r;
                    brc_next   = br_c;
                    r_next     = tl_r;
                    c_next     = tl_c;
                    first_next = 1'b1;
                    accv_next  = 1'b0;
                    sum_next   = '0;
                    state_next = lmat_pkg::ST_SUM;
                end
                else
                begin
                    state_next = lmat_pkg::ST_IDLE;
                end
            end
            lmat_pkg::ST_SUM:
            begin
                if (first_reg)
                begin
                    pix_next = mem_rdata;
                    cnt_next = lmat_pkg::CNT_W'(
                        lmat_pkg::DIM_W'(brr_reg - tlr_reg + ROW_W'(1)) *
                        lmat_pkg::DIM_W'(brc_reg - tlc_reg + COL_W'(1)));
                end
                first_next = 1'b0;
                if (accv_reg)
                    sum_next = sum_reg + lmat_pkg::SUM_W'(mem_rdata);
                accv_next = 1'b1;
                if (c_reg == brc_reg)
                begin
                    c_next = tlc_reg;
                    r_next = r_reg + ROW_W'(1);
                    if (r_reg == brr_reg)
                        state_next = lmat_pkg::ST_SUMW;
                end
                else
                begin
                    c_next = c_reg + COL_W'(1);
                end
            end
            lmat_pkg::ST_SUMW:
            begin
                sum_next   = sum_reg + lmat_pkg::SUM_W'(mem_rdata);
                state_next = lmat_pkg::ST_MUL;
            end
            lmat_pkg::ST_MUL:
            begin
                lhsp_next  = (lmat_pkg::CNT_W+8)'(pix_reg) * (lmat_pkg::CNT_W+8)'(cnt_reg);
                rhs_next   = (lmat_pkg::SUM_W+17)'(17'h10000 - {1'b0, ratio_reg}) *
                             (lmat_pkg::SUM_W+17)'(sum_reg);
                state_next = lmat_pkg::ST_CMP;
            end
            lmat_pkg::ST_CMP:
            begin
                out_next.out_value  = ((lmat_pkg::SUM_W+17)'({lhsp_reg, 16'h0000}) < rhs_reg) ?
                                      lmat_pkg::DARK : lmat_pkg::BRIGHT;
                out_next.out_row    = 12'(emit_row_reg);
                out_next.out_col    = 11'(emit_col_reg);
                out_next.frame_last = is_last;
                out_next.run_last   = 1'b0;
                n_next = n_reg + lmat_pkg::N_W'(1);
                if (is_last)
                begin
                    end_next      = 1'b1;
                    in_row_next   = '0;
                    in_col_next   = '0;
                    emit_row_next = '0;
                    emit_col_next = '0;
                end
                else if (emit_col_reg + COL_W'(1) >= w_eff)
                begin
                    emit_col_next = '0;
                    emit_row_next = emit_row_reg + ROW_W'(1);
                end
                else
                begin
                    emit_col_next = emit_col_reg + COL_W'(1);
                end
                state_next = lmat_pkg::ST_OUT;
            end
            lmat_pkg::ST_OUT:
            begin
                if (out_ready)
                    state_next = more ? lmat_pkg::ST_EVAL : lmat_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lmat_pkg::ST_IDLE;
            end
        endcase

        // a write to a known register restarts the frame position
        if (cfg_we)
        begin
            unique case (cfg_index)
                lmat_pkg::CFG_FRAME_WIDTH:  fw_next     = cfg_wdata[11:0];
                lmat_pkg::CFG_FRAME_HEIGHT: fh_next     = cfg_wdata[12:0];
                lmat_pkg::CFG_HALF_HEIGHT:  hh_cfg_next = cfg_wdata[4:0];
                lmat_pkg::CFG_HALF_WIDTH:   hw_cfg_next = cfg_wdata[4:0];
                lmat_pkg::CFG_RATIO:        ratio_next  = cfg_wdata;
                default:                    ;
            endcase
            if (int'(cfg_index) <= int'(lmat_pkg::CFG_RATIO))
            begin
                in_row_next   = '0;
                in_col_next   = '0;
                emit_row_next = '0;
                emit_col_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lmat_pkg::ST_IDLE;
            fw_reg       <= 12'd640;
            fh_reg       <= 13'd480;
            hh_cfg_reg   <= 5'd7;
            hw_cfg_reg   <= 5'd7;
            ratio_reg    <= 16'd9830;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
            drain_reg    <= 1'b0;
            end_reg      <= 1'b0;
            n_reg        <= '0;
            first_reg    <= 1'b0;
            accv_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fw_reg       <= fw_next;
            fh_reg       <= fh_next;
            hh_cfg_reg   <= hh_cfg_next;
            hw_cfg_reg   <= hw_cfg_next;
            ratio_reg    <= ratio_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            emit_row_reg <= emit_row_next;
            emit_col_reg <= emit_col_next;
            drain_reg    <= drain_next;
            end_reg      <= end_next;
            n_reg        <= n_next;
            first_reg    <= first_next;
            accv_reg     <= accv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_reg   <= pr_next;
        tlr_reg  <= tlr_next;
        tlc_reg  <= tlc_next;
        brr_reg  <= brr_next;
        brc_reg  <= brc_next;
        r_reg    <= r_next;
        c_reg    <= c_next;
        pix_reg  <= pix_next;
        cnt_reg  <= cnt_next;
        sum_reg  <= sum_next;
        lhsp_reg <= lhsp_next;
        rhs_reg  <= rhs_next;
        out_reg  <= out_next;
    end

`include "local_mean_adaptive_threshold_assert.svh"

    `LMAT_ASSERT_IMPL(a_one_at_a_time, in_ready, !out_valid)
    `LMAT_ASSERT_IMPL(a_frame_end_ends_run, out_valid && out_data.frame_last, out_data.run_last)
    `LMAT_ASSERT_IMPL(a_result_budget, out_valid, (n_reg != '0) && (int'(n_reg) <= lmat_pkg::MAX_RESULTS))
    `LMAT_ASSERT_NEXT(a_sum_done_to_mul, state_reg == lmat_pkg::ST_SUMW, state_reg == lmat_pkg::ST_MUL)

endmodule
`default_nettype wire
